// File: src/dts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dts_pkg
// shared types and constants of the deadline task scheduler
// ----------------------------------------------------------------------------
package dts_pkg;

    localparam int ID_W       = 8;
    localparam int DELAY_W    = 16;
    localparam int IVAL_W     = 16;
    localparam int OCC_OUT_W  = 5;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;

    // action codes carried on tuser
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_ADD  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK_SCAN,
        ST_TICK_DRAIN,
        ST_ADD_SCAN,
        ST_FINISH
    } dts_state_t;

    typedef struct packed {
        logic load;      // capture input word, restart scan
        logic issue;     // read table entry at scan index, advance
        logic add_step;  // advance free-slot probe
        logic finish;    // commit table update, load result register
    } dts_cmd_t;

    typedef struct packed {
        logic in_is_add;
        logic last;
        logic probe_free;
        logic out_free;
    } dts_status_t;

endpackage
`default_nettype wire

// File: src/dts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dts_ctrl
// sequencer: steps the datapath through the table scan of one word
// ----------------------------------------------------------------------------
module dts_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  dts_pkg::dts_status_t status,
    output dts_pkg::dts_cmd_t    cmd
);
    import dts_pkg::*;

    dts_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = status.in_is_add ? ST_ADD_SCAN : ST_TICK_SCAN;
                end
            end
            ST_TICK_SCAN: begin
                cmd.issue = 1'b1;
                if (status.last) begin
                    state_next = ST_TICK_DRAIN;
                end
            end
            // last read returns, compared this cycle
            ST_TICK_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_ADD_SCAN: begin
                if (status.probe_free || status.last) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.add_step = 1'b1;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: src/dts_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dts_datapath
// task table memory, valid bits, time counter, earliest-due pick, result reg
// ----------------------------------------------------------------------------
module dts_datapath #(
    parameter int DEPTH      = 16,
    parameter int TIME_WIDTH = 32
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  dts_pkg::dts_cmd_t                  cmd,
    output dts_pkg::dts_status_t               status,
    input  wire [dts_pkg::IN_DATA_W-1:0]       in_data,
    input  wire                                in_user,
    output logic                               out_valid,
    input  wire                                out_ready,
    output logic [dts_pkg::OUT_DATA_W-1:0]     out_data
);
    import dts_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int TW    = TIME_WIDTH;
    // entry layout from bit 0: due, task, repeat, period
    localparam int TASK_LSB = TW;
    localparam int REP_BIT  = TW + ID_W;
    localparam int PER_LSB  = TW + ID_W + 1;
    localparam int ENT_W    = TW + ID_W + 1 + IVAL_W;

    logic [ENT_W-1:0] mem [DEPTH];

    logic [TW-1:0]      now_reg;
    logic [DEPTH-1:0]   valid_reg;
    logic [OCC_W-1:0]   occ_reg, occ_next;

    logic               act_reg;
    logic [ID_W-1:0]    id_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic               per_reg;
    logic [IVAL_W-1:0]  ival_reg;

    logic [IDX_W-1:0]   scan_idx_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               rd_live_reg;
    logic [ENT_W-1:0]   rd_data_reg;

    logic               pick_found_reg;
    logic [IDX_W-1:0]   pick_idx_reg;
    logic [TW-1:0]      pick_due_reg;
    logic [ID_W-1:0]    pick_task_reg;
    logic               pick_rep_reg;
    logic [IVAL_W-1:0]  pick_per_reg;

    logic               out_valid_reg;
    logic               out_disp_reg;
    logic [ID_W-1:0]    out_id_reg;
    logic               out_rearm_reg;
    logic               out_acc_reg;
    logic               out_drop_reg;
    logic [OCC_OUT_W-1:0] out_occ_reg;

    logic [TW-1:0]      rd_due;
    logic [TW-1:0]      age_diff;
    logic [TW-1:0]      order_diff;
    logic               cand_take;
    logic               mem_we;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENT_W-1:0]   wr_data;
    logic               probe_free;
    logic [8:0]         occ_ext;

    // ---------------- status ----------------
    assign probe_free = !valid_reg[scan_idx_reg];

    always_comb begin
        status            = '0;
        status.in_is_add  = (in_user == ACT_ADD);
        status.last       = (scan_idx_reg == IDX_W'(DEPTH - 1));
        status.probe_free = probe_free;
        status.out_free   = !out_valid_reg || out_ready;
    end

    // ---------------- candidate compare ----------------
    assign rd_due     = rd_data_reg[TW-1:0];
    assign age_diff   = now_reg - rd_due;
    assign order_diff = rd_due - pick_due_reg;
    // due when now - due is not negative; replace only when strictly earlier
    assign cand_take  = rd_live_reg && !age_diff[TW-1] &&
                        (!pick_found_reg || order_diff[TW-1]);

    // ---------------- commit decode ----------------
    always_comb begin
        mem_we   = 1'b0;
        wr_addr  = scan_idx_reg;
        wr_data  = {ival_reg, per_reg, id_reg, now_reg + TW'(delay_reg)};
        occ_next = occ_reg;
        if (act_reg == ACT_ADD) begin
            if (probe_free) begin
                mem_we   = cmd.finish;
                occ_next = occ_reg + OCC_W'(1);
            end
        end else if (pick_found_reg) begin
            wr_addr = pick_idx_reg;
            wr_data = {pick_per_reg, pick_rep_reg, pick_task_reg,
                       now_reg + TW'(pick_per_reg)};
            if (pick_rep_reg) begin
                mem_we = cmd.finish;
            end else begin
                occ_next = occ_reg - OCC_W'(1);
            end
        end
    end

    assign occ_ext = 9'(occ_next);

    // ---------------- table memory ----------------
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            rd_data_reg <= mem[scan_idx_reg];
        end
    end

    // ---------------- control state ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg        <= '0;
            valid_reg      <= '0;
            occ_reg        <= '0;
            rd_live_reg    <= 1'b0;
            pick_found_reg <= 1'b0;
            scan_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.load) begin
                scan_idx_reg   <= '0;
                pick_found_reg <= 1'b0;
                if (in_user == ACT_TICK) begin
                    now_reg <= now_reg + TW'(1);
                end
            end else if (cmd.issue || cmd.add_step) begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end
            rd_live_reg <= cmd.issue && valid_reg[scan_idx_reg];
            if (cand_take) begin
                pick_found_reg <= 1'b1;
            end
            if (cmd.finish) begin
                occ_reg <= occ_next;
                if (act_reg == ACT_ADD) begin
                    if (probe_free) begin
                        valid_reg[scan_idx_reg] <= 1'b1;
                    end
                end else if (pick_found_reg && !pick_rep_reg) begin
                    valid_reg[pick_idx_reg] <= 1'b0;
                end
            end
            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg   <= in_user;
            id_reg    <= in_data[ID_W-1:0];
            delay_reg <= in_data[ID_W +: DELAY_W];
            per_reg   <= in_data[ID_W + DELAY_W];
            ival_reg  <= in_data[ID_W + DELAY_W + 1 +: IVAL_W];
        end
        if (cmd.issue) begin
            rd_idx_reg <= scan_idx_reg;
        end
        if (cand_take) begin
            pick_idx_reg  <= rd_idx_reg;
            pick_due_reg  <= rd_due;
            pick_task_reg <= rd_data_reg[TASK_LSB +: ID_W];
            pick_rep_reg  <= rd_data_reg[REP_BIT];
            pick_per_reg  <= rd_data_reg[PER_LSB +: IVAL_W];
        end
        if (cmd.finish) begin
            out_occ_reg <= (occ_ext > 9'd31) ? 5'd31 : occ_ext[4:0];
            if (act_reg == ACT_ADD) begin
                out_disp_reg  <= 1'b0;
                out_id_reg    <= '0;
                out_rearm_reg <= 1'b0;
                out_acc_reg   <= probe_free;
                out_drop_reg  <= !probe_free;
            end else begin
                out_disp_reg  <= pick_found_reg;
                out_id_reg    <= pick_found_reg ? pick_task_reg : '0;
                out_rearm_reg <= pick_found_reg && pick_rep_reg;
                out_acc_reg   <= 1'b0;
                out_drop_reg  <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {7'b0, out_occ_reg, out_drop_reg, out_acc_reg, out_rearm_reg,
                        out_id_reg, out_disp_reg};

    // ---------------- assertions ----------------
    a_occ_tracks_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg == OCC_W'($countones(valid_reg)))
        else $error("occupancy count out of step with valid bits");

    a_finish_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> out_valid_reg)
        else $error("result register not loaded after commit");

    a_add_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_acc_reg && out_drop_reg) &&
                          !(out_disp_reg && (out_acc_reg || out_drop_reg)))
        else $error("conflicting result flags");

    a_tick_advances_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load && in_user == ACT_TICK) |=> now_reg == $past(now_reg) + TW'(1))
        else $error("time counter did not advance on tick");

    a_rearm_needs_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_rearm_reg |-> out_disp_reg)
        else $error("rearm without dispatch");

endmodule
`default_nettype wire

// File: src/deadline_task_scheduler_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deadline_task_scheduler_top
// timed task queue: add tasks with a delay, dispatch the earliest due per tick
// ----------------------------------------------------------------------------
// One input word is handled at a time and gives one result word. For a tick
// word the task table memory is read one entry per cycle to find the earliest
// due task, a drain state compares the last entry read, then a finish state
// commits the dispatch or rearm. An add word walks the valid bits to the
// lowest free slot, then commits in the finish state. The result sits in an
// output register, so the next word is taken while it waits; the block only
// stalls at commit if the previous result is still unread.
module deadline_task_scheduler_top #(
    parameter int DEPTH      = 16,
    parameter int TIME_WIDTH = 32
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // task_id[7:0], delay[23:8], periodic[24], interval[40:25]
    input  wire [dts_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // action[0]
    input  wire                               s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // dispatched[0], dispatched_id[8:1], rearmed[9], add_accepted[10],
    // add_dropped[11], occupancy[16:12]
    output logic [dts_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import dts_pkg::*;

    dts_cmd_t    cmd;
    dts_status_t status;

    dts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dts_datapath #(
        .DEPTH      (DEPTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule
`default_nettype wire
